// ===== hdl/atbp_pkg.sv =====
// Package for the ANSI terminal byte parser: command codes, parse modes,
// the UTF-8 class/transition tables and the item struct passed front to back.
// No dependencies.
package atbp_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TRIM  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] MODE_GROUND = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    localparam logic [3:0] U8_ACCEPT = 4'd0;
    localparam logic [3:0] U8_REJECT = 4'd1;

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;

    // Byte kinds passed from front to back.
    localparam logic [2:0] OP_GLYPH = 3'd0;
    localparam logic [2:0] OP_TAB   = 3'd1;
    localparam logic [2:0] OP_BS    = 3'd2;
    localparam logic [2:0] OP_CR    = 3'd3;
    localparam logic [2:0] OP_LF    = 3'd4;
    localparam logic [2:0] OP_RESET = 3'd5;
    localparam logic [2:0] OP_CSI   = 3'd6;

    localparam int PW = 16;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
    } t_item;

    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] c;
        if (b < 8'h80)       c = 4'd0;
        else if (b < 8'h90)  c = 4'd1;
        else if (b < 8'ha0)  c = 4'd9;
        else if (b < 8'hc0)  c = 4'd7;
        else if (b < 8'hc2)  c = 4'd8;
        else if (b < 8'he0)  c = 4'd2;
        else if (b == 8'he0) c = 4'd10;
        else if (b == 8'hed) c = 4'd4;
        else if (b < 8'hf0)  c = 4'd3;
        else if (b == 8'hf0) c = 4'd11;
        else if (b < 8'hf4)  c = 4'd6;
        else if (b == 8'hf4) c = 4'd5;
        else                 c = 4'd8;
        return c;
    endfunction

    function automatic logic [3:0] u8_next(input logic [3:0] st, input logic [3:0] cls);
        logic [3:0] n;
        n = U8_REJECT;
        case (st)
            4'd0: begin
                case (cls)
                    4'd0: n = 4'd0;
                    4'd2: n = 4'd2;
                    4'd3: n = 4'd3;
                    4'd4: n = 4'd5;
                    4'd5: n = 4'd8;
                    4'd6: n = 4'd7;
                    4'd10: n = 4'd4;
                    4'd11: n = 4'd6;
                    default: n = U8_REJECT;
                endcase
            end
            4'd2: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd0;
            4'd3: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd2;
            4'd4: if (cls == 4'd7) n = 4'd2;
            4'd5: if (cls == 4'd1 || cls == 4'd9) n = 4'd2;
            4'd6: if (cls == 4'd7 || cls == 4'd9) n = 4'd3;
            4'd7: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) n = 4'd3;
            4'd8: if (cls == 4'd1) n = 4'd3;
            default: n = U8_REJECT;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/atbp_fifo.sv =====
// Short item queue between the front classifier and the back executor.
// Depends on atbp_pkg.
module atbp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  atbp_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output atbp_pkg::t_item o_data
);
    import atbp_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
        if (i_wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hdl/atbp_front.sv =====
// Front part: accepts bytes, tracks the ground/escape/CSI mode and
// classifies each byte into an item for the back part. Depends on atbp_pkg.
module atbp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_in_byte,
    output logic            o_wr,
    output atbp_pkg::t_item o_item,
    input  logic            i_full
);
    import atbp_pkg::*;

    logic [1:0] r_mode, n_mode;
    logic       push;
    logic       acc;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        n_mode = r_mode;
        push = 1'b0;
        o_item.op = OP_GLYPH;
        o_item.data = i_in_byte;
        case (r_mode)
            MODE_ESC: begin
                if (i_in_byte == "[") begin
                    n_mode = MODE_CSI;
                    push = 1'b1;
                    o_item.op = OP_CSI;
                end else if (i_in_byte >= "0" && i_in_byte <= "9") begin
                    push = 1'b1;
                    o_item.op = OP_CSI;
                end else begin
                    n_mode = MODE_GROUND;
                    if (i_in_byte == "c") begin
                        push = 1'b1;
                        o_item.op = OP_RESET;
                    end
                end
            end
            MODE_CSI: begin
                push = 1'b1;
                o_item.op = OP_CSI;
                if (!(i_in_byte >= "0" && i_in_byte <= "9") && i_in_byte != ";")
                    n_mode = MODE_GROUND;
            end
            default: begin
                n_mode = MODE_GROUND;
                push = 1'b1;
                case (i_in_byte)
                    CH_ESC: begin
                        n_mode = MODE_ESC;
                        push = 1'b0;
                    end
                    CH_TAB: o_item.op = OP_TAB;
                    CH_BS:  o_item.op = OP_BS;
                    CH_CR:  o_item.op = OP_CR;
                    CH_LF:  o_item.op = OP_LF;
                    default: o_item.op = OP_GLYPH;
                endcase
            end
        endcase
    end

    // Escape-mode '[' is sent as CSI with data '['; back clears the count.
    assign o_wr = acc && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_GROUND;
        else if (acc) r_mode <= n_mode;
    end
endmodule

// ===== hdl/atbp_back.sv =====
// Back part: UTF-8 decoding, CSI parameter collection, SGR walk and cursor.
// Emits write/trim/clear commands into an output register. Depends on atbp_pkg.
module atbp_back #(
    parameter int LINE_COLUMNS = 128,
    parameter int SCREEN_ROWS  = 64,
    parameter int MAX_PARAMS   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  atbp_pkg::t_item i_item,
    output logic            o_rd,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_cmd_kind,
    output logic [6:0]      o_col,
    output logic [5:0]      o_row,
    output logic [20:0]     o_code_point,
    output logic [20:0]     o_style
);
    import atbp_pkg::*;
    localparam int CW = $clog2(LINE_COLUMNS);
    localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int PI = $clog2(MAX_PARAMS);
    localparam int PC = $clog2(MAX_PARAMS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SGR  = 2'd1;

    logic [1:0]    r_st;
    logic [PW-1:0] r_par [MAX_PARAMS];
    logic [PC-1:0] r_pcnt;
    logic [PC-1:0] r_n;
    logic [PC-1:0] r_pi;
    logic [3:0]    r_u8;
    logic [20:0]   r_acc;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [20:0]   r_sty;
    logic          r_ov;
    logic [1:0]    r_kind;
    logic [6:0]    r_ocol;
    logic [5:0]    r_orow;
    logic [20:0]   r_ocp;
    logic [20:0]   r_osty;

    assign o_valid = r_ov;
    assign o_cmd_kind = r_kind;
    assign o_col = r_ocol;
    assign o_row = r_orow;
    assign o_code_point = r_ocp;
    assign o_style = r_osty;

    logic out_free;
    assign out_free = !r_ov || !i_stall;
    assign o_rd = (r_st == S_IDLE) && !i_empty && out_free;

    logic [7:0] b;
    assign b = i_item.data;
    logic is_dig;
    assign is_dig = (b >= "0" && b <= "9");
    logic [3:0] dig;
    assign dig = b[3:0];

    // UTF-8 step
    logic [3:0] cls, st0, nxt;
    logic [20:0] acc;
    logic [7:0]  lead_mask;
    always_comb begin
        cls = byte_class(b);
        st0 = (r_u8 > 4'd8) ? U8_ACCEPT : r_u8;
        lead_mask = 8'hff >> cls;
        if (st0 != U8_ACCEPT) acc = {r_acc[14:0], b[5:0]};
        else acc = 21'(lead_mask & b);
        nxt = u8_next(st0, cls);
        if (nxt == U8_REJECT && st0 != U8_ACCEPT) begin
            acc = 21'(lead_mask & b);
            nxt = u8_next(U8_ACCEPT, cls);
        end
    end

    // Digit accumulate target
    logic [PI-1:0] didx;
    logic [PW-1:0] dcur;
    logic [PW+3:0] dval;
    always_comb begin
        if (r_pcnt == '0) didx = '0;
        else if (r_pcnt > PC'(MAX_PARAMS)) didx = PI'(MAX_PARAMS - 1);
        else didx = PI'(r_pcnt - 1'b1);
        dcur = (r_pcnt == '0) ? '0 : r_par[didx];
        dval = {dcur, 3'b000} + {2'b00, dcur, 1'b0} + (PW+4)'(dig);
    end

    // Cursor helpers
    logic [RW-1:0] row_dn;
    assign row_dn = (32'(r_row) + 1 < SCREEN_ROWS) ? r_row + 1'b1 : r_row;
    logic [CW+2:0] tabc;
    assign tabc = ((CW+3)'(r_col) + (CW+3)'(4)) & ~(CW+3)'(3);
    logic [PW-1:0] p0;
    assign p0 = (r_pcnt != '0) ? r_par[0] : PW'(1);
    logic [PW-1:0] gcol;
    assign gcol = (p0 != '0) ? p0 - 1'b1 : '0;

    // SGR element
    logic [PI-1:0] spi, spi1, spi2;
    logic [PW-1:0] sv, sv1, sv2;
    logic [PC-1:0] rem;
    logic          ext_col;
    logic [PC-1:0] pi_step;
    always_comb begin
        spi = r_pi[PI-1:0];
        spi1 = spi + 1'b1;
        spi2 = spi + 2'd2;
        sv = r_par[spi];
        sv1 = r_par[spi1];
        sv2 = r_par[spi2];
        rem = r_n - r_pi;
        // 38;5;n and 48;5;n consume three parameters
        ext_col = (sv == 16'd38 || sv == 16'd48) && rem >= PC'(3) && sv1 == 16'd5;
        pi_step = ext_col ? PC'(3) : PC'(1);
    end

    // A command is loaded into the output register on this edge
    logic out_set;
    always_comb begin
        out_set = 1'b0;
        if (o_rd) begin
            case (i_item.op)
                OP_CR, OP_LF, OP_RESET: out_set = 1'b1;
                OP_TAB, OP_BS, OP_CSI:  out_set = 1'b0;
                default:                out_set = (nxt == U8_ACCEPT);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pcnt <= '0;
            r_u8 <= U8_ACCEPT;
            r_acc <= '0;
            r_col <= '0;
            r_row <= '0;
            r_sty <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++) r_par[i] <= '0;
        end else begin
            r_ov <= out_set || (r_ov && i_stall);
            if (r_st == S_SGR) begin
                if (r_pi >= r_n) begin
                    r_st <= S_IDLE;
                end else begin
                    r_pi <= r_pi + pi_step;
                    case (sv)
                        16'd0: r_sty <= '0;
                        16'd1: r_sty[0] <= 1'b1;
                        16'd21, 16'd22: r_sty[0] <= 1'b0;
                        16'd4: r_sty[1] <= 1'b1;
                        16'd24: r_sty[1] <= 1'b0;
                        16'd7: r_sty[2] <= 1'b1;
                        16'd27: r_sty[2] <= 1'b0;
                        16'd38: if (ext_col) r_sty[11:3] <= {1'b1, sv2[7:0]};
                        16'd39: r_sty[11:3] <= '0;
                        16'd48: if (ext_col) r_sty[20:12] <= {1'b1, sv2[7:0]};
                        16'd49: r_sty[20:12] <= '0;
                        default: begin
                            if (sv >= 16'd30 && sv <= 16'd37)
                                r_sty[11:3] <= {1'b1, 5'd0, sv[2:0] - 3'd6};
                            else if (sv >= 16'd40 && sv <= 16'd47)
                                r_sty[20:12] <= {1'b1, 5'd0, sv[2:0]};
                        end
                    endcase
                end
            end else if (o_rd) begin
                case (i_item.op)
                    OP_TAB: r_col <= (tabc > (CW+3)'(LINE_COLUMNS-1))
                        ? CW'(LINE_COLUMNS-1) : tabc[CW-1:0];
                    OP_BS: if (r_col != '0) r_col <= r_col - 1'b1;
                    OP_CR, OP_LF: begin
                        r_kind <= CMD_TRIM;
                        r_ocol <= 7'(r_col);
                        r_orow <= 6'(r_row);
                        r_ocp <= '0;
                        r_osty <= '0;
                        r_col <= '0;
                        if (i_item.op == OP_LF) r_row <= row_dn;
                    end
                    OP_RESET: begin
                        r_kind <= CMD_CLEAR;
                        r_ocol <= '0;
                        r_orow <= '0;
                        r_ocp <= '0;
                        r_osty <= '0;
                        r_col <= '0;
                        r_row <= '0;
                        r_sty <= '0;
                        r_u8 <= U8_ACCEPT;
                        r_acc <= '0;
                    end
                    OP_CSI: begin
                        if (b == "[") r_pcnt <= '0;
                        else if (is_dig) begin
                            if (r_pcnt == '0) r_pcnt <= PC'(1);
                            r_par[didx] <= (dval > 20'hffff) ? 16'hffff : dval[PW-1:0];
                        end else if (b == ";") begin
                            if (r_pcnt == '0) begin
                                r_par[0] <= '0;
                                r_par[1] <= '0;
                                r_pcnt <= PC'(2);
                            end else if (r_pcnt < PC'(MAX_PARAMS)) begin
                                r_par[r_pcnt[PI-1:0]] <= '0;
                                r_pcnt <= r_pcnt + 1'b1;
                            end else begin
                                r_par[MAX_PARAMS-1] <= '0;
                            end
                        end else if (b == "A") begin
                            r_row <= (32'(r_row) < 32'(p0)) ? '0 : RW'(32'(r_row) - 32'(p0));
                        end else if (b == "G") begin
                            r_col <= (32'(gcol) > LINE_COLUMNS-1)
                                ? CW'(LINE_COLUMNS-1) : CW'(gcol);
                        end else if (b == "m") begin
                            if (r_pcnt == '0) r_sty <= '0;
                            r_n <= (r_pcnt > PC'(MAX_PARAMS)) ? PC'(MAX_PARAMS) : r_pcnt;
                            r_pi <= '0;
                            r_st <= S_SGR;
                        end
                    end
                    default: begin
                        if (nxt == U8_REJECT) begin
                            r_u8 <= U8_ACCEPT;
                            r_acc <= '0;
                        end else begin
                            r_u8 <= nxt;
                            r_acc <= acc;
                            if (nxt == U8_ACCEPT) begin
                                r_kind <= CMD_WRITE;
                                r_ocol <= 7'(r_col);
                                r_orow <= 6'(r_row);
                                r_ocp <= acc;
                                r_osty <= r_sty;
                                if (32'(r_col) + 1 >= LINE_COLUMNS) begin
                                    r_col <= '0;
                                    r_row <= row_dn;
                                end else r_col <= r_col + 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end
endmodule

// ===== hdl/ansi_terminal_byte_parser.sv =====
// ANSI terminal byte parser, top level: front classifier, item queue and
// back executor. Depends on atbp_pkg, atbp_front, atbp_fifo, atbp_back.
//
// Input channel: i_valid / o_stall with one byte in i_in_byte.
// Output channel: o_valid / i_stall with one command (write cell, trim line,
// clear screen) and its fields on separate ports.
// An item is taken at a clock edge where valid is high and stall is low.
// The front takes one byte per cycle while the two-entry queue has room.
// The back takes one queued item per cycle while its output register is free;
// a CSI m final then walks the stored SGR parameters one per cycle, taking a
// 38;5;n or 48;5;n group at once, and the back takes no item until the walk
// ends. An item is written into the queue when its byte is taken, and its
// result is loaded into the output register when the back reads it.
// Sustained rate: one byte per cycle while the receiver does not stall and
// no SGR walk runs. While the receiver stalls, the held result stays and the
// back waits; the queue keeps filling until full, then o_stall rises.
// Reset (synchronous, active low) returns to ground mode, cursor home, no
// style, UTF-8 decoder in accept, empty queue and no pending result.
module ansi_terminal_byte_parser #(
    parameter int LINE_COLUMNS = 128,
    parameter int SCREEN_ROWS  = 64,
    parameter int MAX_PARAMS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_cmd_kind,
    output logic [6:0]  o_col,
    output logic [5:0]  o_row,
    output logic [20:0] o_code_point,
    output logic        o_is_bold,
    output logic        o_is_underlined,
    output logic        o_is_inverted,
    output logic [7:0]  o_fg_colour,
    output logic        o_fg_valid,
    output logic [7:0]  o_bg_colour,
    output logic        o_bg_valid
);
    import atbp_pkg::*;

    logic  wr, full, rd, empty;
    t_item wdata, rdata;
    logic [20:0] sty;

    atbp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_in_byte(i_in_byte), .o_wr(wr), .o_item(wdata), .i_full(full)
    );

    atbp_fifo #(.DEPTH(2)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(wr), .i_data(wdata), .o_full(full),
        .i_rd(rd), .o_empty(empty), .o_data(rdata)
    );

    atbp_back #(
        .LINE_COLUMNS(LINE_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS), .MAX_PARAMS(MAX_PARAMS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_item(rdata), .o_rd(rd),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd_kind(o_cmd_kind), .o_col(o_col),
        .o_row(o_row), .o_code_point(o_code_point), .o_style(sty)
    );

    assign o_is_bold       = sty[0];
    assign o_is_underlined = sty[1];
    assign o_is_inverted   = sty[2];
    assign o_fg_colour     = sty[10:3];
    assign o_fg_valid      = sty[11];
    assign o_bg_colour     = sty[19:12];
    assign o_bg_valid      = sty[20];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point) && $stable(o_cmd_kind))
        else $error("result changed while stalled");
    a_nowr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !wr)
        else $error("queue written while full");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_kind == CMD_CLEAR |-> o_col == '0 && o_row == '0)
        else $error("clear carries a position");
endmodule

// ===== tb/sv/tb_ansi_terminal_byte_parser.sv =====
// Self-checking testbench for ansi_terminal_byte_parser: random byte streams
// (text, UTF-8, escape and CSI sequences, noise) against a built-in predictor.
// Depends on atbp_pkg and the ansi_terminal_byte_parser RTL.
`timescale 1ns / 1ps

module tb_ansi_terminal_byte_parser;
    import atbp_pkg::*;

    localparam int COLS        = 128;
    localparam int ROWS        = 64;
    localparam int NPARAM      = 8;
    localparam int N_ITEMS     = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_MARK  = -1;

    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_C        = 8'h63;
    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_COL     = 8'h47;
    localparam logic [7:0] FIN_SGR     = 8'h6d;

    localparam int SGR_RESET = 0,  SGR_BOLD = 1,  SGR_UNDER = 4,  SGR_INV = 7;
    localparam int SGR_NOBOLD_A = 21, SGR_NOBOLD_B = 22;
    localparam int SGR_NOUNDER = 24, SGR_NOINV = 27;
    localparam int SGR_FG_EXT = 38, SGR_FG_DEF = 39, SGR_BG_EXT = 48, SGR_BG_DEF = 49;
    localparam int SGR_PALETTE = 5;

    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  col;
        logic [5:0]  row;
        logic [20:0] cp;
        logic        bold, under, inv;
        logic [7:0]  fg;
        logic        fg_ok;
        logic [7:0]  bg;
        logic        bg_ok;
    } t_cmd;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_in_byte = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_cmd_kind;
    logic [6:0]  o_col;
    logic [5:0]  o_row;
    logic [20:0] o_code_point;
    logic        o_is_bold, o_is_underlined, o_is_inverted;
    logic [7:0]  o_fg_colour, o_bg_colour;
    logic        o_fg_valid, o_bg_valid;

    ansi_terminal_byte_parser dut (.*);

    initial forever #6 i_clk = ~i_clk;

    // predictor state
    logic [1:0]  mode;
    int unsigned prm [NPARAM];
    int unsigned pcount;
    logic [3:0]  dec_state;
    logic [20:0] dec_acc;
    int unsigned cur_col, cur_row;
    logic        st_bold, st_under, st_inv, st_fg_ok, st_bg_ok;
    logic [7:0]  st_fg, st_bg;

    logic [3:0] dfa_next [9][12] = '{
        '{0, 1, 2, 3, 5, 8, 7, 1, 1, 1, 4, 6},
        '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1},
        '{1, 0, 1, 1, 1, 1, 1, 0, 1, 0, 1, 1},
        '{1, 2, 1, 1, 1, 1, 1, 2, 1, 2, 1, 1},
        '{1, 1, 1, 1, 1, 1, 1, 2, 1, 1, 1, 1},
        '{1, 2, 1, 1, 1, 1, 1, 1, 1, 2, 1, 1},
        '{1, 1, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1},
        '{1, 3, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1},
        '{1, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1}
    };

    t_cmd cmd_q[$];
    int   stim_q[$];
    int   errors = 0;
    int   cycles = 0;
    int   taken_cnt = 0;
    int   drains = 0;
    logic in_taken = 0;

    function automatic int lead_class(input logic [7:0] b);
        if (b < 8'h80) return 0;
        if (b < 8'h90) return 1;
        if (b < 8'ha0) return 9;
        if (b < 8'hc0) return 7;
        if (b < 8'hc2) return 8;
        if (b < 8'he0) return 2;
        if (b == 8'he0) return 10;
        if (b == 8'hed) return 4;
        if (b < 8'hf0) return 3;
        if (b == 8'hf0) return 11;
        if (b < 8'hf4) return 6;
        if (b == 8'hf4) return 5;
        return 8;
    endfunction

    task automatic clear_style();
        {st_bold, st_under, st_inv, st_fg_ok, st_bg_ok} = '0;
        st_fg = 0;
        st_bg = 0;
    endtask

    task automatic reset_model();
        mode = MODE_GROUND;
        foreach (prm[i]) prm[i] = 0;
        pcount = 0;
        dec_state = U8_ACCEPT;
        dec_acc = 0;
        cur_col = 0;
        cur_row = 0;
        clear_style();
    endtask

    task automatic push_cmd(input logic [1:0] k, input int unsigned c, input int unsigned r,
                            input logic [20:0] cp, input logic styled);
        t_cmd e;
        e.kind = k; e.col = c[6:0]; e.row = r[5:0]; e.cp = cp;
        e.bold = styled & st_bold; e.under = styled & st_under; e.inv = styled & st_inv;
        e.fg = styled ? st_fg : 8'd0; e.fg_ok = styled & st_fg_ok;
        e.bg = styled ? st_bg : 8'd0; e.bg_ok = styled & st_bg_ok;
        cmd_q.push_back(e);
    endtask

    task automatic row_down();
        if (cur_row + 1 < ROWS) cur_row++;
    endtask

    task automatic add_digit(input int unsigned d);
        int unsigned i, v;
        if (pcount == 0) begin
            prm[0] = 0;
            pcount = 1;
        end
        i = (pcount - 1 >= NPARAM) ? NPARAM - 1 : pcount - 1;
        v = prm[i] * 10 + d;
        prm[i] = (v > 65535) ? 65535 : v;
    endtask

    task automatic add_separator();
        if (pcount == 0) begin
            prm[0] = 0;
            pcount = 1;
        end
        if (pcount < NPARAM) begin
            prm[pcount] = 0;
            pcount++;
        end else begin
            prm[NPARAM-1] = 0;
        end
    endtask

    task automatic apply_sgr();
        int unsigned n, k, v;
        n = (pcount > NPARAM) ? NPARAM : pcount;
        if (n == 0) clear_style();
        k = 0;
        while (k < n) begin
            v = prm[k];
            if (v == SGR_RESET) clear_style();
            else if (v == SGR_BOLD) st_bold = 1;
            else if (v == SGR_NOBOLD_A || v == SGR_NOBOLD_B) st_bold = 0;
            else if (v == SGR_UNDER) st_under = 1;
            else if (v == SGR_NOUNDER) st_under = 0;
            else if (v == SGR_INV) st_inv = 1;
            else if (v == SGR_NOINV) st_inv = 0;
            else if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
                if (n - k >= 3 && prm[k+1] == SGR_PALETTE) begin
                    if (v == SGR_FG_EXT) begin
                        st_fg = prm[k+2][7:0]; st_fg_ok = 1;
                    end else begin
                        st_bg = prm[k+2][7:0]; st_bg_ok = 1;
                    end
                    k += 2;
                end
            end
            else if (v == SGR_FG_DEF) begin
                st_fg = 0; st_fg_ok = 0;
            end
            else if (v == SGR_BG_DEF) begin
                st_bg = 0; st_bg_ok = 0;
            end
            else if (v >= 30 && v <= 37) begin
                st_fg = v - 30; st_fg_ok = 1;
            end
            else if (v >= 40 && v <= 47) begin
                st_bg = v - 40; st_bg_ok = 1;
            end
            k++;
        end
    endtask

    // returns 1 when a code point completes
    function automatic logic decode_utf8(input logic [7:0] b);
        int cls;
        logic [3:0]  nxt;
        logic [20:0] acc;
        cls = lead_class(b);
        if (dec_state != U8_ACCEPT) acc = {dec_acc[14:0], b[5:0]};
        else acc = 21'(8'hff >> cls) & 21'(b);
        nxt = dfa_next[dec_state][cls];
        if (nxt == U8_REJECT && dec_state != U8_ACCEPT) begin
            acc = 21'(8'hff >> cls) & 21'(b);
            nxt = dfa_next[U8_ACCEPT][cls];
        end
        if (nxt == U8_REJECT) begin
            dec_state = U8_ACCEPT;
            dec_acc = 0;
            return 0;
        end
        dec_state = nxt;
        dec_acc = acc;
        return nxt == U8_ACCEPT;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        int unsigned n, c, r;
        if (mode == MODE_ESC) begin
            if (b == CH_LBRACKET) begin
                pcount = 0;
                mode = MODE_CSI;
            end else if (b >= "0" && b <= "9") begin
                add_digit(b - "0");
            end else begin
                mode = MODE_GROUND;
                if (b == CH_C) begin
                    cur_col = 0; cur_row = 0;
                    clear_style();
                    dec_state = U8_ACCEPT; dec_acc = 0;
                    push_cmd(CMD_CLEAR, 0, 0, 0, 0);
                end
            end
        end else if (mode == MODE_CSI) begin
            if (b >= "0" && b <= "9") add_digit(b - "0");
            else if (b == CH_SEMI) add_separator();
            else begin
                n = pcount ? prm[0] : 1;
                if (b == FIN_UP) cur_row = (cur_row < n) ? 0 : cur_row - n;
                else if (b == FIN_COL) begin
                    if (n) n--;
                    cur_col = (n > COLS - 1) ? COLS - 1 : n;
                end else if (b == FIN_SGR) apply_sgr();
                mode = MODE_GROUND;
            end
        end else begin
            mode = MODE_GROUND;
            if (b == CH_ESC) mode = MODE_ESC;
            else if (b == CH_TAB) begin
                c = (cur_col + 4) & ~32'd3;
                cur_col = (c > COLS - 1) ? COLS - 1 : c;
            end else if (b == CH_BS) begin
                if (cur_col) cur_col--;
            end else if (b == CH_LF || b == CH_CR) begin
                c = cur_col; r = cur_row;
                cur_col = 0;
                if (b == CH_LF) row_down();
                push_cmd(CMD_TRIM, c, r, 0, 0);
            end else if (decode_utf8(b)) begin
                c = cur_col; r = cur_row;
                cur_col++;
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    row_down();
                end
                push_cmd(CMD_WRITE, c, r, dec_acc, 1);
            end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        if (errors < 20) $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_cmd();
        t_cmd e;
        if (cmd_q.size() == 0) begin
            report("command with none pending", o_cmd_kind, 0);
            return;
        end
        e = cmd_q.pop_front();
        if (o_cmd_kind !== e.kind) report("cmd_kind", o_cmd_kind, e.kind);
        if (o_col !== e.col) report("col", o_col, e.col);
        if (o_row !== e.row) report("row", o_row, e.row);
        if (o_code_point !== e.cp) report("code_point", o_code_point, e.cp);
        if (o_is_bold !== e.bold) report("is_bold", o_is_bold, e.bold);
        if (o_is_underlined !== e.under) report("is_underlined", o_is_underlined, e.under);
        if (o_is_inverted !== e.inv) report("is_inverted", o_is_inverted, e.inv);
        if (o_fg_colour !== e.fg) report("fg_colour", o_fg_colour, e.fg);
        if (o_fg_valid !== e.fg_ok) report("fg_valid", o_fg_valid, e.fg_ok);
        if (o_bg_colour !== e.bg) report("bg_colour", o_bg_colour, e.bg);
        if (o_bg_valid !== e.bg_ok) report("bg_valid", o_bg_valid, e.bg_ok);
    endtask

    // sampling and checking
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ansi_terminal_byte_parser: mismatch");
            $finish;
        end else begin
            in_taken <= i_rst_n && i_valid && !o_stall;
            if (i_rst_n && i_valid && !o_stall) begin
                predict_byte(i_in_byte);
                taken_cnt++;
            end
            if (i_rst_n && o_valid && !i_stall) check_cmd();
        end
    end

    function automatic int pick_gap();
        int r;
        if ((taken_cnt / 150) % 3 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // byte driver
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 0;
            end else if (stim_q.size() > 0 && stim_q[0] == DRAIN_MARK) begin
                i_valid <= 0;
                if (cmd_q.size() == 0) void'(stim_q.pop_front());
            end else if (stim_q.size() > 0) begin
                i_valid <= 1;
                i_in_byte <= 8'(stim_q.pop_front());
                gap_left = pick_gap();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // command receiver backpressure
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(negedge i_clk) begin
        if (!hold_done && taken_cnt >= 700) begin
            hold_done = 1;
            hold_left = 250;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1;
        end else begin
            stall_left = pick_gap();
            i_stall <= (stall_left > 0);
        end
    end

    int n_bytes = 0;

    task automatic put(input logic [7:0] b);
        stim_q.push_back(b);
        n_bytes++;
    endtask

    task automatic put_num(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_utf8(input int unsigned cp);
        if (cp < 'h80) put(cp);
        else if (cp < 'h800) begin
            put(8'hc0 | (cp >> 6)); put(8'h80 | (cp & 'h3f));
        end else if (cp < 'h10000) begin
            put(8'he0 | (cp >> 12)); put(8'h80 | ((cp >> 6) & 'h3f));
            put(8'h80 | (cp & 'h3f));
        end else begin
            put(8'hf0 | (cp >> 18)); put(8'h80 | ((cp >> 12) & 'h3f));
            put(8'h80 | ((cp >> 6) & 'h3f)); put(8'h80 | (cp & 'h3f));
        end
    endtask

    function automatic int unsigned sgr_value();
        int unsigned codes [16] = '{0, 1, 4, 7, 21, 22, 24, 27, 33, 39, 45, 49, 38, 48, 5, 99};
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return codes[$urandom_range(0, 15)];
        if (r < 9) return $urandom_range(0, 300);
        return $urandom_range(60000, 2000000);
    endfunction

    task automatic put_csi_sgr();
        int np;
        put(CH_ESC); put(CH_LBRACKET);
        np = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) begin
            // palette colour form
            put_num($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT); put(CH_SEMI);
            put_num(SGR_PALETTE); put(CH_SEMI); put_num($urandom_range(0, 511));
            if (np > 0) put(CH_SEMI);
        end
        for (int i = 0; i < np; i++) begin
            if ($urandom_range(0, 5) != 0) put_num(sgr_value());
            if (i != np - 1) put(CH_SEMI);
        end
        put(FIN_SGR);
    endtask

    task automatic put_random_unit();
        int r, len;
        int unsigned cp;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            len = $urandom_range(1, 40);
            repeat (len) put($urandom_range(8'h20, 8'h7e));
        end else if (r < 45) begin
            case ($urandom_range(0, 3))
                0: cp = $urandom_range('h80, 'h7ff);
                1: cp = $urandom_range('h800, 'hd7ff);
                2: cp = $urandom_range('he000, 'hffff);
                default: cp = $urandom_range('h10000, 'h10ffff);
            endcase
            put_utf8(cp);
        end else if (r < 62) put_csi_sgr();
        else if (r < 70) begin
            put(CH_ESC); put(CH_LBRACKET);
            if ($urandom_range(0, 3) != 0) put_num($urandom_range(0, 200));
            put($urandom_range(0, 1) ? FIN_UP : FIN_COL);
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0: put(CH_TAB);
                1: put(CH_BS);
                2: put(CH_CR);
                default: put(CH_LF);
            endcase
        end else if (r < 83) begin
            put(CH_ESC);
            if ($urandom_range(0, 1)) put_num($urandom_range(0, 99));
            put($urandom_range(0, 2) ? CH_C : $urandom_range(0, 255));
        end else if (r < 87) begin
            // broken CSI with random final or random content
            put(CH_ESC); put(CH_LBRACKET);
            repeat ($urandom_range(0, 4)) put($urandom_range(0, 255));
        end else begin
            repeat ($urandom_range(1, 4)) put($urandom_range(0, 255));
        end
    endtask

    initial begin
        reset_model();
        // directed opening
        put("A"); put(8'h00); put(8'hff); put(8'h7f); put(CH_TAB); put(CH_BS);
        put(CH_CR); put(CH_LF); put(8'hc3); put(8'ha9); put(8'hc3); put(CH_LF);
        put(8'ha9); put(8'he2); put(8'h41); put(8'hf4); put(8'h8f); put(8'hbf); put(8'hbf);
        put(CH_ESC); put(CH_C);
        put(CH_ESC); put(CH_LBRACKET); put(CH_SEMI); put(FIN_SGR);
        put(CH_ESC); put(CH_LBRACKET); put_num(99999); put(FIN_COL); put("x");
        put(CH_ESC); put(CH_LBRACKET); put_num(1); put(CH_SEMI); put_num(4); put(CH_SEMI);
        put_num(7); put(CH_SEMI); put_num(38); put(CH_SEMI); put_num(5); put(CH_SEMI);
        put_num(200); put(CH_SEMI); put_num(48); put(CH_SEMI); put_num(5); put(CH_SEMI);
        put_num(17); put(FIN_SGR); put("y");
        put(CH_ESC); put(CH_LBRACKET); put_num(3); put(FIN_UP);
        while (n_bytes < N_ITEMS) begin
            put_random_unit();
            // sender pauses until every expected command has come
            if ((n_bytes > 400 && drains == 0) || (n_bytes > 1200 && drains == 1)) begin
                stim_q.push_back(DRAIN_MARK);
                drains++;
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;

        while (stim_q.size() != 0 || i_valid) @(posedge i_clk);
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && cmd_q.size() == 0)
            $display("ansi_terminal_byte_parser: match");
        else
            $display("ansi_terminal_byte_parser: mismatch");
        $finish;
    end

endmodule
